FILE: sv/uoi_pkg.sv
// Shared constants, command codes and the arctangent table of the odometry integrator.
`default_nettype none

package uoi_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int ITER_W       = $clog2(CORDIC_ITERS);
   localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

   localparam logic CMD_SET_VEL = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   localparam logic [15:0] STEP_TIME_RESET = 16'd1966;

   localparam logic signed [32:0] PI_Q29       = 33'sd1686629713;
   localparam logic signed [32:0] HALF_PI_Q29  = 33'sd843314857;
   localparam logic signed [31:0] CORDIC_START = 32'sd652032875;

   localparam logic signed [21:0] PI_Q13     = 22'sd25736;
   localparam logic signed [21:0] TWO_PI_Q13 = 22'sd51472;

   localparam logic signed [50:0] ROUND_Q11 = 51'sd1024;
   localparam logic signed [65:0] ROUND_Q38 = 66'sd137438953472;
   localparam logic signed [32:0] ROUND_Q16 = 33'sd32768;

   localparam logic signed [32:0] POS_MAX = 33'sh0_7FFFFFFF;
   localparam logic signed [32:0] POS_MIN = 33'sh1_80000000;
   localparam logic signed [16:0] QUAT_MAX = 17'sd16384;

   function automatic logic signed [32:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [32:0] val;
      case (idx)
         5'd0:    val = 33'sd421657428;
         5'd1:    val = 33'sd248918915;
         5'd2:    val = 33'sd131521918;
         5'd3:    val = 33'sd66762579;
         5'd4:    val = 33'sd33510843;
         5'd5:    val = 33'sd16771758;
         5'd6:    val = 33'sd8387925;
         5'd7:    val = 33'sd4194219;
         5'd8:    val = 33'sd2097141;
         5'd9:    val = 33'sd1048575;
         5'd10:   val = 33'sd524288;
         5'd11:   val = 33'sd262144;
         5'd12:   val = 33'sd131072;
         5'd13:   val = 33'sd65536;
         5'd14:   val = 33'sd32768;
         5'd15:   val = 33'sd16384;
         5'd16:   val = 33'sd8192;
         5'd17:   val = 33'sd4096;
         5'd18:   val = 33'sd2048;
         5'd19:   val = 33'sd1024;
         5'd20:   val = 33'sd512;
         5'd21:   val = 33'sd256;
         5'd22:   val = 33'sd128;
         5'd23:   val = 33'sd64;
         default: val = 33'sd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: sv/unicycle_odometry_integrator.sv
// Unicycle dead-reckoning pose integrator with a shared CORDIC and multiplier.
//
// Input channel req_*: one transaction is either a set-velocity command, which
// latches req_lin_speed and req_ang_speed and produces no response, or a tick,
// which advances x, y and heading by one step of csr_step_time seconds and
// produces one response transaction on rsp_* (pose plus yaw quaternion).
// Configuration channel csr_*: writes the step time; it is always ready.
// A set-velocity command completes in the idle state. A tick occupies the block
// from acceptance until it leaves its last step, ST_QUAT; rsp_valid rises as
// the tick leaves ST_QUAT, and req_ready returns in the same cycle.
// A tick makes two passes through the single CORDIC rotator, one
// iteration per cycle, plus six products through one 34x17 multiplier.
// The response sits in an output register: the block accepts the next
// transaction while it waits, and a later tick holds in its last step until
// the receiver has taken the earlier response.
// Synchronous reset clears pose, speeds, the pending response, and loads the
// default step time (0.03 s).
`default_nettype none

module unicycle_odometry_integrator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_command,
   input  wire logic signed [15:0] req_lin_speed,
   input  wire logic signed [15:0] req_ang_speed,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [15:0]      rsp_heading,
   output logic signed [15:0]      rsp_quat_z,
   output logic signed [15:0]      rsp_quat_w,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [15:0]        csr_step_time
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DTV,
      ST_DTW,
      ST_WRAP,
      ST_CSET,
      ST_CROT,
      ST_CEND,
      ST_PLO,
      ST_PHI,
      ST_PRND,
      ST_PSUM,
      ST_QUAT
   } state_type;

   localparam logic [uoi_pkg::ITER_W-1:0] ITER_LAST =
      uoi_pkg::ITER_W'(uoi_pkg::CORDIC_ITERS - 1);

   state_type                      state_ff, state_in;
   logic [15:0]                    step_time_ff, step_time_in;
   logic signed [15:0]             held_lin_ff, held_lin_in;
   logic signed [15:0]             held_ang_ff, held_ang_in;
   logic signed [31:0]             x_acc_ff, x_acc_in;
   logic signed [31:0]             y_acc_ff, y_acc_in;
   logic signed [15:0]             yaw_ff, yaw_in;
   logic signed [15:0]             new_yaw_ff, new_yaw_in;
   logic signed [21:0]             hraw_ff, hraw_in;
   logic signed [33:0]             dtv_ff, dtv_in;
   logic signed [31:0]             cx_ff, cx_in;
   logic signed [31:0]             sy_ff, sy_in;
   logic signed [32:0]             ang_ff, ang_in;
   logic                           neg_ff, neg_in;
   logic [uoi_pkg::ITER_W-1:0]     iter_ff, iter_in;
   logic                           pass_ff, pass_in;
   logic                           axis_ff, axis_in;
   logic signed [65:0]             acc_ff, acc_in;
   logic signed [25:0]             rnd_ff, rnd_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]             rsp_pos_x_ff, rsp_pos_x_in;
   logic signed [31:0]             rsp_pos_y_ff, rsp_pos_y_in;
   logic signed [15:0]             rsp_heading_ff, rsp_heading_in;
   logic signed [15:0]             rsp_quat_z_ff, rsp_quat_z_in;
   logic signed [15:0]             rsp_quat_w_ff, rsp_quat_w_in;

   logic signed [33:0]             mul_a;
   logic signed [16:0]             mul_b;
   logic signed [50:0]             mul_p;
   logic signed [31:0]             cur_c;

   logic                           req_fire;
   logic signed [50:0]             hsum;
   logic signed [21:0]             hwrap1;
   logic signed [21:0]             hwrap2;
   logic signed [32:0]             ang_raw;
   logic signed [31:0]             xs;
   logic signed [31:0]             ys;
   logic signed [32:0]             atan_val;
   logic signed [65:0]             rsum;
   logic signed [31:0]             pbase;
   logic signed [32:0]             psum;
   logic signed [31:0]             psat;
   logic signed [32:0]             qzsum;
   logic signed [32:0]             qwsum;
   logic signed [16:0]             qz;
   logic signed [16:0]             qw;
   logic                           out_free;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = rsp_pos_x_ff;
   assign rsp_pos_y   = rsp_pos_y_ff;
   assign rsp_heading = rsp_heading_ff;
   assign rsp_quat_z  = rsp_quat_z_ff;
   assign rsp_quat_w  = rsp_quat_w_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   assign cur_c = axis_ff ? sy_ff : cx_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_DTV: begin
            mul_a = {18'd0, step_time_ff};
            mul_b = {held_lin_ff[15], held_lin_ff};
         end
         ST_DTW: begin
            mul_a = {18'd0, step_time_ff};
            mul_b = {held_ang_ff[15], held_ang_ff};
         end
         ST_PLO: begin
            mul_a = dtv_ff;
            mul_b = {1'b0, cur_c[15:0]};
         end
         ST_PHI: begin
            mul_a = dtv_ff;
            mul_b = {cur_c[31], cur_c[31:16]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      hsum     = mul_p + uoi_pkg::ROUND_Q11;
      hwrap1   = (hraw_ff > uoi_pkg::PI_Q13) ? hraw_ff - uoi_pkg::TWO_PI_Q13 : hraw_ff;
      hwrap2   = (hwrap1 < -uoi_pkg::PI_Q13) ? hwrap1 + uoi_pkg::TWO_PI_Q13 : hwrap1;
      ang_raw  = pass_ff ? ({{17{new_yaw_ff[15]}}, new_yaw_ff} << 15)
                         : ({{17{yaw_ff[15]}}, yaw_ff} << 16);
      xs       = cx_ff >>> iter_ff;
      ys       = sy_ff >>> iter_ff;
      atan_val = uoi_pkg::atan_q29(uoi_pkg::ATAN_IDX_W'(iter_ff));
      rsum     = acc_ff + uoi_pkg::ROUND_Q38;
      pbase    = axis_ff ? y_acc_ff : x_acc_ff;
      psum     = {pbase[31], pbase} + {{7{rnd_ff[25]}}, rnd_ff};
      if (psum > uoi_pkg::POS_MAX) begin
         psat = 32'sh7FFFFFFF;
      end else if (psum < uoi_pkg::POS_MIN) begin
         psat = 32'sh80000000;
      end else begin
         psat = psum[31:0];
      end
      qzsum = {sy_ff[31], sy_ff} + uoi_pkg::ROUND_Q16;
      qwsum = {cx_ff[31], cx_ff} + uoi_pkg::ROUND_Q16;
      qz    = qzsum[32:16];
      qw    = qwsum[32:16];
      if (qz > uoi_pkg::QUAT_MAX) begin
         qz = uoi_pkg::QUAT_MAX;
      end else if (qz < -uoi_pkg::QUAT_MAX) begin
         qz = -uoi_pkg::QUAT_MAX;
      end
      if (qw > uoi_pkg::QUAT_MAX) begin
         qw = uoi_pkg::QUAT_MAX;
      end else if (qw < -uoi_pkg::QUAT_MAX) begin
         qw = -uoi_pkg::QUAT_MAX;
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_time_in   = step_time_ff;
      held_lin_in    = held_lin_ff;
      held_ang_in    = held_ang_ff;
      x_acc_in       = x_acc_ff;
      y_acc_in       = y_acc_ff;
      yaw_in         = yaw_ff;
      new_yaw_in     = new_yaw_ff;
      hraw_in        = hraw_ff;
      dtv_in         = dtv_ff;
      cx_in          = cx_ff;
      sy_in          = sy_ff;
      ang_in         = ang_ff;
      neg_in         = neg_ff;
      iter_in        = iter_ff;
      pass_in        = pass_ff;
      axis_in        = axis_ff;
      acc_in         = acc_ff;
      rnd_in         = rnd_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_pos_x_in   = rsp_pos_x_ff;
      rsp_pos_y_in   = rsp_pos_y_ff;
      rsp_heading_in = rsp_heading_ff;
      rsp_quat_z_in  = rsp_quat_z_ff;
      rsp_quat_w_in  = rsp_quat_w_ff;

      if (csr_valid && csr_ready) begin
         step_time_in = csr_step_time;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_command == uoi_pkg::CMD_SET_VEL) begin
                  held_lin_in = req_lin_speed;
                  held_ang_in = req_ang_speed;
               end else begin
                  pass_in  = 1'b0;
                  axis_in  = 1'b0;
                  state_in = ST_DTV;
               end
            end
         end
         ST_DTV: begin
            dtv_in   = mul_p[33:0];
            state_in = ST_DTW;
         end
         ST_DTW: begin
            hraw_in  = {{6{yaw_ff[15]}}, yaw_ff} + hsum[32:11];
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            if (hwrap2 > uoi_pkg::PI_Q13) begin
               new_yaw_in = uoi_pkg::PI_Q13[15:0];
            end else if (hwrap2 < -uoi_pkg::PI_Q13) begin
               new_yaw_in = -uoi_pkg::PI_Q13[15:0];
            end else begin
               new_yaw_in = hwrap2[15:0];
            end
            state_in = ST_CSET;
         end
         ST_CSET: begin
            cx_in   = uoi_pkg::CORDIC_START;
            sy_in   = '0;
            iter_in = '0;
            if (ang_raw > uoi_pkg::HALF_PI_Q29) begin
               ang_in = ang_raw - uoi_pkg::PI_Q29;
               neg_in = 1'b1;
            end else if (ang_raw < -uoi_pkg::HALF_PI_Q29) begin
               ang_in = ang_raw + uoi_pkg::PI_Q29;
               neg_in = 1'b1;
            end else begin
               ang_in = ang_raw;
               neg_in = 1'b0;
            end
            state_in = ST_CROT;
         end
         ST_CROT: begin
            if (!ang_ff[32]) begin
               cx_in  = cx_ff - ys;
               sy_in  = sy_ff + xs;
               ang_in = ang_ff - atan_val;
            end else begin
               cx_in  = cx_ff + ys;
               sy_in  = sy_ff - xs;
               ang_in = ang_ff + atan_val;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_LAST) begin
               state_in = ST_CEND;
            end
         end
         ST_CEND: begin
            if (neg_ff) begin
               cx_in = -cx_ff;
               sy_in = -sy_ff;
            end
            state_in = pass_ff ? ST_QUAT : ST_PLO;
         end
         ST_PLO: begin
            acc_in   = 66'(mul_p);
            state_in = ST_PHI;
         end
         ST_PHI: begin
            acc_in   = acc_ff + (66'(mul_p) <<< 16);
            state_in = ST_PRND;
         end
         ST_PRND: begin
            rnd_in   = rsum[63:38];
            state_in = ST_PSUM;
         end
         ST_PSUM: begin
            if (!axis_ff) begin
               x_acc_in = psat;
               axis_in  = 1'b1;
               state_in = ST_PLO;
            end else begin
               y_acc_in = psat;
               pass_in  = 1'b1;
               state_in = ST_CSET;
            end
         end
         ST_QUAT: begin
            if (out_free) begin
               yaw_in         = new_yaw_ff;
               rsp_valid_in   = 1'b1;
               rsp_pos_x_in   = x_acc_ff;
               rsp_pos_y_in   = y_acc_ff;
               rsp_heading_in = new_yaw_ff;
               rsp_quat_z_in  = qz[15:0];
               rsp_quat_w_in  = qw[15:0];
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_time_ff <= uoi_pkg::STEP_TIME_RESET;
         held_lin_ff  <= '0;
         held_ang_ff  <= '0;
         x_acc_ff     <= '0;
         y_acc_ff     <= '0;
         yaw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= 1'b0;
         axis_ff      <= 1'b0;
         iter_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         step_time_ff <= step_time_in;
         held_lin_ff  <= held_lin_in;
         held_ang_ff  <= held_ang_in;
         x_acc_ff     <= x_acc_in;
         y_acc_ff     <= y_acc_in;
         yaw_ff       <= yaw_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
         axis_ff      <= axis_in;
         iter_ff      <= iter_in;
      end
      new_yaw_ff     <= new_yaw_in;
      hraw_ff        <= hraw_in;
      dtv_ff         <= dtv_in;
      cx_ff          <= cx_in;
      sy_ff          <= sy_in;
      ang_ff         <= ang_in;
      neg_ff         <= neg_in;
      acc_ff         <= acc_in;
      rnd_ff         <= rnd_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_pos_y_ff   <= rsp_pos_y_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_quat_z_ff  <= rsp_quat_z_in;
      rsp_quat_w_ff  <= rsp_quat_w_in;
   end

`ifndef ASSERT_OFF
   a_rsp_from_final_step : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_QUAT))
      else $error("response raised outside the final step");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QUAT && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_QUAT))
      else $error("tick finished over a pending response");

   a_heading_range : assert property (@(posedge clock) disable iff (reset)
      !(state_ff == ST_IDLE) || (yaw_ff <= 16'sd25736 && yaw_ff >= -16'sd25736))
      else $error("heading outside [-pi, pi]");

   a_iter_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CROT) |-> (iter_ff <= ITER_LAST))
      else $error("CORDIC iteration count overrun");
`endif

endmodule

`default_nettype wire
